// ----- sv/assert_macros.svh -----
// assertion helper macros for the lfu store unit rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// plain property checked on every clock outside reset
`define KVS_ASSERT(lbl, clk_i, rstn_i, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (prop)) \
    else $error("lfu kvs assertion failed");

// overlapping implication checked outside reset
`define KVS_ASSERT_IMP(lbl, clk_i, rstn_i, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
    else $error("lfu kvs assertion failed");

`else

`define KVS_ASSERT(lbl, clk_i, rstn_i, prop)
`define KVS_ASSERT_IMP(lbl, clk_i, rstn_i, ante, cons)

`endif

`endif

// ----- sv/lfu_kvs_pkg.sv -----
// ----------------------------------------------------------------------------
// lfu_kvs_pkg
// Beat types and fixed constants of the lfu key/value store.
// ----------------------------------------------------------------------------
package lfu_kvs_pkg;

  // width and reset value of the capacity register
  localparam int unsigned CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // action codes
  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  // value returned on a get miss and on every put
  localparam logic signed [31:0] READ_MISS = -32'sd1;

  // input beat
  typedef struct packed {
    logic               action;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } in_item_t;

  // result beat
  typedef struct packed {
    logic               found;
    logic signed [31:0] read_value;
    logic               evicted;
    logic signed [31:0] evicted_key;
  } out_item_t;

endpackage

// ----- sv/lfu_cache_key_value_store_unit.sv -----
// ----------------------------------------------------------------------------
// lfu_cache_key_value_store_unit
// Least-frequently-used key/value cache with a single entry ram.
// ----------------------------------------------------------------------------
// One item is handled at a time. After an input beat is taken the block reads
// the occupied slots of the entry ram one per cycle, matching the key and
// tracking the lowest use count (lowest slot wins a tie); a match ends the
// scan early. A decide state then waits for a free result register, writes
// the entry back and loads the result register. Slots fill from index zero
// and an eviction reuses its slot at once, so an occupancy counter marks the
// valid slots: nothing needs clearing after reset. The next input beat is
// taken while a result still waits on a stalled output. Capacity is written
// through the cfg port, which is always ready; zero acts as one and values
// above ENTRIES act as ENTRIES.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lfu_cache_key_value_store_unit #(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  lfu_kvs_pkg::in_item_t        in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output lfu_kvs_pkg::out_item_t       out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [lfu_kvs_pkg::CAP_W-1:0] cfg_data
);

  import lfu_kvs_pkg::*;

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  typedef struct packed {
    logic [31:0]           key;
    logic [31:0]           value;
    logic [COUNT_BITS-1:0] count;
  } entry_t;

  localparam int unsigned ENT_W = $bits(entry_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } state_t;

  // control registers
  state_t           state_r, state_nxt;
  logic [CAP_W-1:0] capacity_r, capacity_nxt;
  logic [CNT_W-1:0] used_r, used_nxt;
  logic [CNT_W-1:0] issue_idx_r, issue_idx_nxt;
  logic             cmp_vld_r, cmp_vld_nxt;
  logic             hit_r, hit_nxt;
  logic             min_vld_r, min_vld_nxt;
  logic             out_valid_r, out_valid_nxt;

  // payload registers
  in_item_t              req_r, req_nxt;
  logic [CNT_W-1:0]      cmp_idx_r;
  logic [IDX_W-1:0]      hit_idx_r, hit_idx_nxt;
  logic [31:0]           hit_val_r, hit_val_nxt;
  logic [COUNT_BITS-1:0] hit_cnt_r, hit_cnt_nxt;
  logic [IDX_W-1:0]      min_idx_r, min_idx_nxt;
  logic [COUNT_BITS-1:0] min_cnt_r, min_cnt_nxt;
  logic [31:0]           min_key_r, min_key_nxt;
  out_item_t             out_data_r, out_data_nxt;

  // ram port signals
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic [ENT_W-1:0] ram_rdata;
  entry_t           rd_ent;

  // helpers
  logic             in_fire;
  logic             issue_active;
  logic             cmp_match;
  logic             cmp_less;
  logic             out_free;
  logic             decide_fire;
  logic             is_put;
  logic             full;
  logic [CAP_W-1:0] cap_nz;

  assign rd_ent = entry_t'(ram_rdata);

  lfu_kvs_ram #(
    .DEPTH(ENTRIES),
    .WIDTH(ENT_W)
  ) u_ram (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_addr(issue_idx_r[IDX_W-1:0]),
    .rd_data(ram_rdata)
  );

  // handshake outputs
  assign in_stall  = (state_r != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // scan pipeline: address issue and compare of the returned entry
  assign issue_active = (state_r == ST_SCAN) && !hit_r && (issue_idx_r < used_r);
  assign cmp_match    = cmp_vld_r && (rd_ent.key == req_r.key);
  assign cmp_less     = cmp_vld_r && (!min_vld_r || (rd_ent.count < min_cnt_r));

  // eviction decision
  assign is_put   = (req_r.action == ACT_PUT);
  assign cap_nz   = (capacity_r == '0) ? CAP_W'(1) : capacity_r;
  assign full     = (used_r == CNT_W'(ENTRIES)) || (CMP_W'(used_r) >= CMP_W'(cap_nz));
  assign out_free = !out_valid_r || !out_stall;
  assign decide_fire = (state_r == ST_DECIDE) && out_free;

  // entry write-back
  always_comb begin
    ram_we          = decide_fire && (hit_r || is_put);
    ram_wdata.key   = req_r.key;
    ram_wdata.value = req_r.value;
    ram_wdata.count = COUNT_BITS'(1);
    if (hit_r) begin
      ram_waddr = hit_idx_r;
      if (is_put) begin
        ram_wdata.count = hit_cnt_r;
      end else begin
        ram_wdata.value = hit_val_r;
        ram_wdata.count = (hit_cnt_r == '1) ? hit_cnt_r : hit_cnt_r + COUNT_BITS'(1);
      end
    end else if (full) begin
      ram_waddr = min_idx_r;
    end else begin
      ram_waddr = used_r[IDX_W-1:0];
    end
  end

  // next state and registers
  always_comb begin
    state_nxt     = state_r;
    capacity_nxt  = capacity_r;
    used_nxt      = used_r;
    issue_idx_nxt = issue_idx_r;
    cmp_vld_nxt   = issue_active;
    hit_nxt       = hit_r;
    min_vld_nxt   = min_vld_r;
    out_valid_nxt = out_valid_r;
    req_nxt       = req_r;
    hit_idx_nxt   = hit_idx_r;
    hit_val_nxt   = hit_val_r;
    hit_cnt_nxt   = hit_cnt_r;
    min_idx_nxt   = min_idx_r;
    min_cnt_nxt   = min_cnt_r;
    min_key_nxt   = min_key_r;
    out_data_nxt  = out_data_r;

    // capacity write
    if (cfg_valid && cfg_ready) begin
      capacity_nxt = cfg_data;
    end

    // result register drain
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          req_nxt       = in_data;
          issue_idx_nxt = '0;
          hit_nxt       = 1'b0;
          min_vld_nxt   = 1'b0;
          state_nxt     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (issue_active) begin
          issue_idx_nxt = issue_idx_r + CNT_W'(1);
        end
        if (cmp_less) begin
          min_vld_nxt = 1'b1;
          min_idx_nxt = cmp_idx_r[IDX_W-1:0];
          min_cnt_nxt = rd_ent.count;
          min_key_nxt = rd_ent.key;
        end
        if (cmp_match) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = cmp_idx_r[IDX_W-1:0];
          hit_val_nxt = rd_ent.value;
          hit_cnt_nxt = rd_ent.count;
          state_nxt   = ST_DECIDE;
        end else if (!issue_active && !cmp_vld_r) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.found      = hit_r;
          out_data_nxt.read_value = (hit_r && !is_put) ? signed'(hit_val_r) : READ_MISS;
          out_data_nxt.evicted    = is_put && !hit_r && full;
          out_data_nxt.evicted_key = (is_put && !hit_r && full) ? signed'(min_key_r) : '0;
          if (is_put && !hit_r && !full) begin
            used_nxt = used_r + CNT_W'(1);
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state, control, payload and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      capacity_r  <= CAP_RESET;
      used_r      <= '0;
      issue_idx_r <= '0;
      cmp_vld_r   <= 1'b0;
      hit_r       <= 1'b0;
      min_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      capacity_r  <= capacity_nxt;
      used_r      <= used_nxt;
      issue_idx_r <= issue_idx_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      hit_r       <= hit_nxt;
      min_vld_r   <= min_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r      <= req_nxt;
    cmp_idx_r  <= issue_idx_r;
    hit_idx_r  <= hit_idx_nxt;
    hit_val_r  <= hit_val_nxt;
    hit_cnt_r  <= hit_cnt_nxt;
    min_idx_r  <= min_idx_nxt;
    min_cnt_r  <= min_cnt_nxt;
    min_key_r  <= min_key_nxt;
    out_data_r <= out_data_nxt;
  end

  // occupancy never passes the slot count
  `KVS_ASSERT(a_used_bound, clk, rst_n, used_r <= CNT_W'(ENTRIES))
  // occupancy only steps up by one
  `KVS_ASSERT_IMP(a_used_step, clk, rst_n, used_r != $past(used_r), used_r == $past(used_r) + CNT_W'(1))
  // ram data is compared only in the cycle after a scan read
  `KVS_ASSERT_IMP(a_cmp_after_scan, clk, rst_n, cmp_vld_r, $past(state_r) == ST_SCAN)
  // a hit never evicts
  `KVS_ASSERT_IMP(a_hit_no_evict, clk, rst_n, out_valid_r, !(out_data_r.found && out_data_r.evicted))

endmodule

// ----- sv/lfu_kvs_ram.sv -----
// ----------------------------------------------------------------------------
// lfu_kvs_ram
// Entry storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lfu_kvs_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 80,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- tb/sv/lfu_cache_key_value_store_unit_checker.sv -----
// ----------------------------------------------------------------------------
// lfu_cache_key_value_store_unit_checker
// Watches the beats of the lfu key/value store, predicts every reply and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module lfu_cache_key_value_store_unit_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  lfu_kvs_pkg::in_item_t             in_data,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  lfu_kvs_pkg::out_item_t            out_data,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [lfu_kvs_pkg::CAP_W-1:0]     cfg_data,
  output int                                fail_count,
  output int                                outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import lfu_kvs_pkg::*;

  localparam int SLOTS   = 16;
  localparam int COUNT_W = 16;

  // shadow copy of the cache contents and the capacity register
  logic [CAP_W-1:0]   capacity;
  logic               slot_used [SLOTS];
  logic signed [31:0] slot_key  [SLOTS];
  logic signed [31:0] slot_val  [SLOTS];
  logic [COUNT_W-1:0] slot_hits [SLOTS];

  out_item_t pending_replies [$];
  out_item_t want;
  out_item_t reply;
  int        mismatches;
  int        reply_no;

  task automatic report_error(input string msg);
    $display("ERROR %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic int effective_cap(input logic [CAP_W-1:0] c);
    if (c == '0) return 1;
    if (c > SLOTS) return SLOTS;
    return int'(c);
  endfunction

  // one get or put against the shadow cache
  task automatic cache_access(input in_item_t it, output out_item_t res);
    int i;
    int hit;
    int free_slot;
    int victim;
    int used;
    res.found       = 1'b0;
    res.read_value  = READ_MISS;
    res.evicted     = 1'b0;
    res.evicted_key = '0;
    hit = -1;
    for (i = 0; i < SLOTS; i++) begin
      if (hit < 0 && slot_used[i] && slot_key[i] == it.key) hit = i;
    end
    if (it.action == ACT_GET) begin
      if (hit >= 0) begin
        res.found      = 1'b1;
        res.read_value = slot_val[hit];
        // count sticks at its top value
        if (slot_hits[hit] != {COUNT_W{1'b1}}) slot_hits[hit] = slot_hits[hit] + 1'b1;
      end
    end else if (hit >= 0) begin
      // update in place, count unchanged
      res.found     = 1'b1;
      slot_val[hit] = it.value;
    end else begin
      used      = 0;
      free_slot = -1;
      for (i = 0; i < SLOTS; i++) begin
        if (slot_used[i]) used++;
        else if (free_slot < 0) free_slot = i;
      end
      // full: drop the least used entry, lowest slot among equals
      if (used >= effective_cap(capacity) || free_slot < 0) begin
        victim = -1;
        for (i = 0; i < SLOTS; i++) begin
          if (slot_used[i] && (victim < 0 || slot_hits[i] < slot_hits[victim])) victim = i;
        end
        if (victim >= 0) begin
          res.evicted       = 1'b1;
          res.evicted_key   = slot_key[victim];
          slot_used[victim] = 1'b0;
          free_slot         = victim;
        end
      end
      if (free_slot >= 0) begin
        slot_used[free_slot] = 1'b1;
        slot_key[free_slot]  = it.key;
        slot_val[free_slot]  = it.value;
        slot_hits[free_slot] = COUNT_W'(1);
      end
    end
  endtask

  // sample every channel at the clock edge
  always @(posedge clk) begin
    if (!rst_n) begin
      capacity = CAP_RESET;
      for (int i = 0; i < SLOTS; i++) begin
        slot_used[i] = 1'b0;
        slot_key[i]  = '0;
        slot_val[i]  = '0;
        slot_hits[i] = '0;
      end
      pending_replies.delete();
    end else begin
      if (cfg_valid && cfg_ready) capacity = cfg_data;
      // result beat against the oldest prediction
      if (out_valid && !out_stall) begin
        if (pending_replies.size() == 0) begin
          report_error($sformatf("result beat %0d with nothing expected", reply_no));
        end else begin
          want = pending_replies.pop_front();
          if (out_data.found !== want.found)
            report_error($sformatf("beat %0d found got %b expected %b",
                                   reply_no, out_data.found, want.found));
          if (out_data.read_value !== want.read_value)
            report_error($sformatf("beat %0d read_value got %h expected %h",
                                   reply_no, out_data.read_value, want.read_value));
          if (out_data.evicted !== want.evicted)
            report_error($sformatf("beat %0d evicted got %b expected %b",
                                   reply_no, out_data.evicted, want.evicted));
          if (out_data.evicted_key !== want.evicted_key)
            report_error($sformatf("beat %0d evicted_key got %h expected %h",
                                   reply_no, out_data.evicted_key, want.evicted_key));
        end
        reply_no++;
      end
      // input beat: predict its reply
      if (in_valid && !in_stall) begin
        cache_access(in_data, reply);
        pending_replies.push_back(reply);
      end
    end
    outstanding <= pending_replies.size();
    fail_count  <= mismatches;
  end

endmodule

// ----- tb/sv/lfu_cache_key_value_store_unit_test.sv -----
// ----------------------------------------------------------------------------
// lfu_cache_key_value_store_unit_test
// Stimulus and verdict for the lfu key/value store: a hot key run, directed
// hits, misses, updates and evictions across capacity settings, then random
// gets and puts over small key pools with random gaps and stalls.
// ----------------------------------------------------------------------------
module lfu_cache_key_value_store_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lfu_kvs_pkg::*;

  localparam int SLOTS        = 16;
  localparam int HOLD_CYCLES  = 400;
  localparam int WATCHDOG     = 5000;
  localparam int PHASE_ITEMS  = 180;
  localparam int HOT_GETS     = 8;
  localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] KEY_HOT = 32'sh5A5A_0001;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  in_item_t         in_data   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_data  = '0;
  int               fail_count;
  int               outstanding;

  bit               fast_mode = 1'b0;
  bit               paced     = 1'b0;
  int               free_beats = 0;
  logic signed [31:0] key_pool [32];

  lfu_cache_key_value_store_unit #(
    .ENTRIES    (SLOTS),
    .COUNT_BITS (16)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  lfu_cache_key_value_store_unit_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // idle length: mostly none or short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // offer one input beat and hold it until taken
  task automatic send_item(input in_item_t it);
    int gap;
    gap = paced ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic do_get(input logic signed [31:0] k);
    in_item_t it;
    it.action = ACT_GET;
    it.key    = k;
    it.value  = $urandom;
    send_item(it);
  endtask

  task automatic do_put(input logic signed [31:0] k, input logic signed [31:0] v);
    in_item_t it;
    it.action = ACT_PUT;
    it.key    = k;
    it.value  = v;
    send_item(it);
  endtask

  // stop offering until every reply is back, then let the block settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SLOTS + 8) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] c);
    cfg_valid <= 1'b1;
    cfg_data  <= c;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic int effective_cap(input logic [CAP_W-1:0] c);
    if (c == '0) return 1;
    if (c > SLOTS) return SLOTS;
    return int'(c);
  endfunction

  // key pool with the corner keys mixed in
  task automatic build_pool(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 9);
      case (r)
        0: key_pool[i] = KEY_MAX;
        1: key_pool[i] = KEY_MIN;
        2: key_pool[i] = '0;
        3: key_pool[i] = -32'sd1;
        default: key_pool[i] = $urandom;
      endcase
    end
  endtask

  // receiver stalls: random segments, one long hold-off, none in fast mode
  initial begin
    int run;
    bit held;
    held = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (fast_mode) begin
        @(posedge clk);
        out_stall <= 1'b0;
      end else if (!held && free_beats >= 100) begin
        held = 1'b1;
        repeat (HOLD_CYCLES) begin
          @(posedge clk);
          out_stall <= 1'b1;
        end
      end else begin
        run = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 150) : 1 + idle_len();
        repeat (run) begin
          @(posedge clk);
          out_stall <= 1'b0;
        end
        run = idle_len();
        repeat (run) begin
          @(posedge clk);
          out_stall <= 1'b1;
        end
      end
    end
  end

  // result beats seen outside fast mode, to place the hold-off
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall && !fast_mode) free_beats <= free_beats + 1;
  end

  // watchdog on cycles without any beat
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= WATCHDOG) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    int caps [8];
    int n;
    int eff;
    int r;
    in_item_t it;
    caps = '{16, 5, 1, 24, 8, 0, 3, 12};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // hot key: one key read back to back
    fast_mode = 1'b1;
    paced     = 1'b0;
    do_get('0);
    do_put(KEY_HOT, 32'sh1234_5678);
    repeat (HOT_GETS) do_get(KEY_HOT);
    wait_idle();
    fast_mode = 1'b0;
    paced     = 1'b1;

    // corner keys and values, hits, update in place
    do_put(KEY_MAX, KEY_MIN);
    do_put(KEY_MIN, KEY_MAX);
    do_put(-32'sd1, -32'sd1);
    do_get(KEY_MAX);
    do_get(KEY_MIN);
    do_get(KEY_MIN);
    do_put(KEY_MAX, '0);
    do_get(KEY_MAX);
    do_get(-32'sd1);
    do_put('0, '0);
    wait_idle();

    // capacity below the number in use
    write_capacity(5'd2);
    do_put(32'sd1, 32'sd1);
    do_put(32'sd2, 32'sd2);
    do_get(32'sd1);
    do_get(KEY_HOT);
    wait_idle();

    // zero acts as one
    write_capacity(5'd0);
    do_put(32'sd3, 32'sd3);
    do_get(32'sd3);
    wait_idle();

    // above the slot count acts as the slot count
    write_capacity(5'd31);
    do_put(32'sd4, 32'sd4);
    do_put(32'sd5, 32'sd5);
    do_get(32'sd4);
    do_put(32'sd4, KEY_MIN);
    wait_idle();

    // random phases over small key pools
    for (int p = 0; p < 9; p++) begin
      r = (p < 8) ? caps[p] : $urandom_range(17, 30);
      write_capacity(r[CAP_W-1:0]);
      eff = effective_cap(r[CAP_W-1:0]);
      n = $urandom_range(2, eff + 10);
      if (n > 32) n = 32;
      build_pool(n);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        it.action = ($urandom_range(0, 99) < 45) ? ACT_PUT : ACT_GET;
        it.key    = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, n - 1)];
        it.value  = $urandom;
        send_item(it);
        if ($urandom_range(0, 149) == 0) wait_idle();
      end
      wait_idle();
    end

    if (fail_count == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/lfu_kvs_pkg.sv
sv/lfu_kvs_ram.sv
sv/lfu_cache_key_value_store_unit.sv
tb/sv/lfu_cache_key_value_store_unit_checker.sv
tb/sv/lfu_cache_key_value_store_unit_test.sv
